>>> rtl/bfl_pkg.sv
`default_nettype none

package bfl_pkg;

    // Pixel and register field widths
    localparam int PIX_W      = 8;
    localparam int WIN_W      = 6;
    localparam int LEN_W      = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    // Defaults for the top-level size parameters
    localparam int MAX_WINDOW_DEFAULT = 63;
    localparam int MAX_LINE_DEFAULT   = 4096;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH = 1'd1;

    // Register values after reset
    localparam logic [WIN_W-1:0] WIN_RESET = 6'd1;
    localparam logic [LEN_W-1:0] LEN_RESET = 13'd640;

endpackage

`default_nettype wire

>>> rtl/bfl_cell.sv
`default_nettype none

// One tap of the variable-length delay line. The cell at position S-1 takes
// the newest padded value; every other cell takes its upper neighbor, so
// cell 0 holds the value pushed S pushes ago.
module bfl_cell #(
    parameter int IDX = 0,
    parameter int S_W = 6
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_shift,
    input  wire logic [S_W-1:0]           i_win,
    input  wire logic [bfl_pkg::PIX_W-1:0] i_new,
    input  wire logic [bfl_pkg::PIX_W-1:0] i_next,
    output logic      [bfl_pkg::PIX_W-1:0] o_data
);

    logic                      w_tail;
    logic [bfl_pkg::PIX_W-1:0] r_data;

    // this cell is the entry point of the line for the current window
    assign w_tail = (i_win == S_W'(IDX + 1));

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_data <= w_tail ? i_new : i_next;
        end
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

>>> rtl/bfl_div_stage.sv
`default_nettype none

// One restoring-division step: resolves one quotient bit of sum / window.
module bfl_div_stage #(
    parameter int SUM_W = 14,
    parameter int S_W   = 6,
    parameter int SHIFT = 0
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_adv,
    input  wire logic [S_W-1:0]            i_div,
    input  wire logic                      i_valid,
    input  wire logic [SUM_W-1:0]          i_rem,
    input  wire logic [bfl_pkg::PIX_W-1:0] i_quo,
    input  wire logic                      i_last,
    output logic                           o_valid,
    output logic      [SUM_W-1:0]          o_rem,
    output logic      [bfl_pkg::PIX_W-1:0] o_quo,
    output logic                           o_last
);

    localparam int DIV_W = SUM_W + bfl_pkg::PIX_W;

    logic [DIV_W-1:0] w_num;
    logic [DIV_W-1:0] w_den;
    logic [DIV_W-1:0] w_diff;
    logic             w_ge;

    // trial subtract of the shifted divisor
    assign w_num  = DIV_W'(i_rem);
    assign w_den  = DIV_W'(i_div) << SHIFT;
    assign w_ge   = (w_num >= w_den);
    assign w_diff = w_num - w_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_adv) begin
            o_valid <= i_valid;
            o_rem   <= w_ge ? w_diff[SUM_W-1:0] : i_rem;
            o_quo   <= {i_quo[bfl_pkg::PIX_W-2:0], w_ge};
            o_last  <= i_last;
        end
    end

endmodule

`default_nettype wire

>>> rtl/box_filter_line_replicate_edges.sv
`default_nettype none

// Box filter over one line of 8-bit pixels with replicated edges. Each line of
// line_length pixels gives line_length outputs, each the truncated mean of a
// window of window_size padded pixels; tlast marks the final output of a
// line. A window at or above the line length is cut to the largest odd value
// below it (minimum 1). Throughput is one pixel per cycle while the output is
// not backpressured, except that the padding sequencer replicates the first
// pixel of a line (S-1)/2 times and the last pixel S-1-(S-1)/2 times, S being
// the window in use, and holds the input while it pushes these copies; it
// pushes one padded value per cycle, when not stalled, into a delay line of
// cells. A result passes through the issue register and eight divider steps,
// the last being the output register. A backpressured output stalls the whole
// pipeline. Configuration writes are accepted at any time, must only be issued
// while the block is idle, and restart the current line.
module box_filter_line_replicate_edges #(
    parameter int MAX_WINDOW = bfl_pkg::MAX_WINDOW_DEFAULT,
    parameter int MAX_LINE   = bfl_pkg::MAX_LINE_DEFAULT
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input stream
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    input  wire logic [bfl_pkg::PIX_W-1:0]     i_s_tdata,   // [7:0] pixel_in
    // output stream
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    output logic      [bfl_pkg::PIX_W-1:0]     o_m_tdata,   // [7:0] pixel_out
    output logic                               o_m_tlast,   // line_end
    // configuration writes
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [bfl_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [bfl_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int PIX_W = bfl_pkg::PIX_W;
    localparam int S_W   = $clog2(MAX_WINDOW + 1);
    localparam int L_W   = $clog2(MAX_LINE + 1);
    localparam int P_W   = $clog2(MAX_LINE);
    localparam int SUM_W = $clog2(((1 << PIX_W) - 1) * MAX_WINDOW + 1);

    // configuration registers
    logic [bfl_pkg::WIN_W-1:0] r_win;
    logic [bfl_pkg::LEN_W-1:0] r_len;

    // line state
    logic [P_W-1:0]   r_pos;
    logic [S_W-1:0]   r_fill;
    logic [SUM_W-1:0] r_sum;
    logic [S_W-1:0]   r_rem;
    logic             r_eol;
    logic [PIX_W-1:0] r_pix;

    // issue register in front of the divider
    logic             r_iv;
    logic [SUM_W-1:0] r_isum;
    logic             r_ilast;

    logic [L_W-1:0]   w_line;
    logic [S_W-1:0]   w_sat;
    logic [S_W-1:0]   w_s;
    logic [S_W-1:0]   w_lead;
    logic [S_W-1:0]   w_trail;
    logic [S_W-1:0]   w_extra;
    logic             w_is_eol;
    logic             w_adv;
    logic             w_acc;
    logic             w_cfg_acc;
    logic             w_busy_push;
    logic             w_push;
    logic             w_push_eol;
    logic             w_emit;
    logic [PIX_W-1:0] w_pv;
    logic [PIX_W-1:0] w_sub;
    logic [SUM_W-1:0] w_n_sum;
    logic [S_W-1:0]   w_n_fill;

    logic [PIX_W-1:0] w_cell [MAX_WINDOW];

    logic             w_dv   [PIX_W+1];
    logic [SUM_W-1:0] w_drem [PIX_W+1];
    logic [PIX_W-1:0] w_dquo [PIX_W+1];
    logic             w_dlast[PIX_W+1];

    // effective line length
    always_comb begin
        if (r_len == '0) begin
            w_line = L_W'(1);
        end else if (32'(r_len) > MAX_LINE) begin
            w_line = L_W'(MAX_LINE);
        end else begin
            w_line = L_W'(r_len);
        end
    end

    // effective window, clamped below the line length
    always_comb begin
        if (r_win == '0) begin
            w_sat = S_W'(1);
        end else if (32'(r_win) > MAX_WINDOW) begin
            w_sat = S_W'(MAX_WINDOW);
        end else begin
            w_sat = S_W'(r_win);
        end
        if (32'(w_sat) >= 32'(w_line)) begin
            if (w_line < L_W'(2)) begin
                w_s = S_W'(1);
            end else begin
                w_s = S_W'({w_line[L_W-1:1], 1'b0} - L_W'(1));
            end
        end else begin
            w_s = w_sat;
        end
    end

    // padding pushes owed by the pixel being accepted
    assign w_is_eol = ({{(L_W-P_W){1'b0}}, r_pos} == w_line - L_W'(1));
    assign w_lead   = (r_pos == '0) ? ((w_s - S_W'(1)) >> 1) : '0;
    assign w_trail  = w_is_eol ? (w_s - S_W'(1) - ((w_s - S_W'(1)) >> 1)) : '0;
    assign w_extra  = w_lead + w_trail;

    // handshakes
    assign w_adv       = !o_m_tvalid || i_m_tready;
    assign o_s_tready  = (r_rem == '0) && w_adv;
    assign w_acc       = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;
    assign w_cfg_acc   = i_cfg_valid;

    // one padded value enters per push
    assign w_busy_push = (r_rem != '0) && w_adv;
    assign w_push      = w_acc || w_busy_push;
    assign w_pv        = w_acc ? i_s_tdata : r_pix;
    assign w_push_eol  = w_acc ? (w_is_eol && (w_extra == '0))
                               : (r_eol && (r_rem == S_W'(1)));

    // running sum: add the newest value, drop the one S pushes back
    assign w_sub    = (r_fill >= w_s) ? w_cell[0] : '0;
    assign w_n_sum  = r_sum - SUM_W'(w_sub) + SUM_W'(w_pv);
    assign w_emit   = (r_fill >= w_s - S_W'(1));
    assign w_n_fill = (r_fill < w_s) ? r_fill + S_W'(1) : r_fill;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win  <= bfl_pkg::WIN_RESET;
            r_len  <= bfl_pkg::LEN_RESET;
            r_pos  <= '0;
            r_fill <= '0;
            r_sum  <= '0;
            r_rem  <= '0;
            r_eol  <= 1'b0;
            r_iv   <= 1'b0;
        end else if (w_cfg_acc) begin
            unique case (i_cfg_index)
                bfl_pkg::REG_WINDOW_SIZE: begin
                    r_win <= i_cfg_data[bfl_pkg::WIN_W-1:0];
                end
                bfl_pkg::REG_LINE_LENGTH: begin
                    r_len <= i_cfg_data[bfl_pkg::LEN_W-1:0];
                end
                default: begin
                end
            endcase
            r_pos  <= '0;
            r_fill <= '0;
            r_sum  <= '0;
            r_rem  <= '0;
            r_eol  <= 1'b0;
        end else begin
            // padding sequencer
            if (w_acc) begin
                r_pix <= i_s_tdata;
                r_rem <= w_extra;
                r_eol <= w_is_eol;
                r_pos <= w_is_eol ? '0 : r_pos + P_W'(1);
            end else if (w_busy_push) begin
                r_rem <= r_rem - S_W'(1);
            end
            // window accumulator, cleared after the last push of a line
            if (w_push) begin
                if (w_push_eol) begin
                    r_fill <= '0;
                    r_sum  <= '0;
                end else begin
                    r_fill <= w_n_fill;
                    r_sum  <= w_n_sum;
                end
            end
            // completed windows go to the divider
            if (w_adv) begin
                r_iv    <= w_push && w_emit;
                r_isum  <= w_n_sum;
                r_ilast <= w_push_eol;
            end
        end
    end

    // delay line of window history cells
    for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
        logic [PIX_W-1:0] w_next;
        if (g == MAX_WINDOW - 1) begin : g_top
            assign w_next = w_pv;
        end else begin : g_mid
            assign w_next = w_cell[g+1];
        end
        bfl_cell #(
            .IDX (g),
            .S_W (S_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_shift (w_push),
            .i_win   (w_s),
            .i_new   (w_pv),
            .i_next  (w_next),
            .o_data  (w_cell[g])
        );
    end

    // divider pipeline, most significant quotient bit first
    assign w_dv[0]    = r_iv;
    assign w_drem[0]  = r_isum;
    assign w_dquo[0]  = '0;
    assign w_dlast[0] = r_ilast;

    for (genvar k = 0; k < PIX_W; k++) begin : g_div
        bfl_div_stage #(
            .SUM_W (SUM_W),
            .S_W   (S_W),
            .SHIFT (PIX_W - 1 - k)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_div   (w_s),
            .i_valid (w_dv[k]),
            .i_rem   (w_drem[k]),
            .i_quo   (w_dquo[k]),
            .i_last  (w_dlast[k]),
            .o_valid (w_dv[k+1]),
            .o_rem   (w_drem[k+1]),
            .o_quo   (w_dquo[k+1]),
            .o_last  (w_dlast[k+1])
        );
    end

    // the last divider step is the output register
    assign o_m_tvalid = w_dv[PIX_W];
    assign o_m_tdata  = w_dquo[PIX_W];
    assign o_m_tlast  = w_dlast[PIX_W];

endmodule

`default_nettype wire
